// ===== hdl/dhme_pkg.sv =====
// Package for the Diffie-Hellman modular exponentiation block.
// Holds payload structs, register indexes, state enums and the serial-unit command.
// No dependencies.
package dhme_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GENERATOR = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SECRET    = 2'd2;

    typedef struct packed {
        logic                      operation;
        logic [VALUE_BITS_DEF-1:0] peer_value;
    } req_t;

    typedef struct packed {
        logic [VALUE_BITS_DEF-1:0] key_value;
        logic                      modulus_not_prime;
    } rsp_t;

    // operation of the bit-serial arithmetic unit
    typedef enum logic [1:0] {
        SOP_REM,   // a mod b by restoring division, one quotient bit a cycle
        SOP_MUL,   // a * b mod m by add-and-double, one multiplier bit a cycle
        SOP_SQDIV  // d*d by add-and-double (no reduction), for the trial bound
    } sop_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMALL,
        ST_DIVA,
        ST_DIVB,
        ST_BOUND,
        ST_REDBASE,
        ST_EXP_MUL,
        ST_EXP_SQR,
        ST_EXP_NEXT,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/dh_modexp_with_prime_check_top.sv =====
// Top level: Diffie-Hellman modular exponentiation with 6k+-1 primality check.
// Depends on dhme_pkg and dhme_serial_unit.
//
//  channel | signals                          | moves
//  in      | in_valid / in_ready / in_data    | request (operation, peer_value)
//  out     | out_valid / out_ready / out_data | result (key_value, flag)
//  cfg     | cfg_we / cfg_index / cfg_data    | register write, no wait
//
// Flow: every request runs the primality test on the modulus, then, if the
// modulus is prime, the exponentiation. One serial unit does all the arithmetic,
// one bit a cycle, for each remainder, modular product or bound square. Trial
// division runs about sqrt(p)/6 steps of three such operations (two remainders
// and one bound square); the exponentiation adds up to 2*VALUE_BITS products
// and passes through ST_EXP_NEXT once per exponent bit.
// Reset clears control state and loads register reset values. A stalled
// result waits in the output register; the next request is taken only once
// that register is empty or is being emptied in the same cycle.
module dh_modexp_with_prime_check_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dhme_pkg::req_t        in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dhme_pkg::rsp_t        out_data,
    input  logic                  cfg_we,
    input  logic [dhme_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [dhme_pkg::VALUE_BITS_DEF-1:0] cfg_data
);
    import dhme_pkg::*;

    localparam int W   = VALUE_BITS_DEF;
    localparam int EBC = $clog2(W + 1);

    // configuration registers
    logic [W-1:0] modulus_reg, generator_reg, secret_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= '0;
            generator_reg <= W'(2);
            secret_reg    <= W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS:   modulus_reg   <= cfg_data;
                REG_GENERATOR: generator_reg <= cfg_data;
                REG_SECRET:    secret_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t         state_reg, state_next;
    logic [W-1:0]   base_reg, base_next;    // peer or generator, later reduced
    logic [W-1:0]   d_reg, d_next;          // trial divisor
    logic [W-1:0]   e_reg, e_next;          // exponent shift register
    logic [EBC-1:0] ecnt_reg, ecnt_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic           go_reg, go_next;        // unit launched, wait for result
    logic           ov_reg, ov_next;
    rsp_t           res_reg, res_next;

    logic           su_start, su_busy;
    sop_t           su_op;
    logic [W-1:0]   su_a, su_b;
    logic [2*W-1:0] su_result;
    logic [W:0]     d_plus;

    dhme_serial_unit #(.VALUE_BITS(W)) u_su (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (su_start),
        .op     (su_op),
        .a      (su_a),
        .b      (su_b),
        .m      (modulus_reg),
        .busy   (su_busy),
        .result (su_result)
    );

    // a new request enters when idle and the output register is free or leaving
    assign in_ready  = (state_reg == ST_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign out_data  = res_reg;
    assign d_plus    = {1'b0, d_reg} + (W+1)'(2);

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        ecnt_next  = ecnt_reg;
        acc_next   = acc_reg;
        go_next    = go_reg;
        ov_next    = ov_reg;
        res_next   = res_reg;
        su_start   = 1'b0;
        su_op      = SOP_REM;
        su_a       = modulus_reg;
        su_b       = d_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    base_next  = in_data.operation ? in_data.peer_value : generator_reg;
                    state_next = ST_SMALL;
                end
            end
            ST_SMALL:
            begin
                // trivial cases: 0, 1 not prime; 2, 3 prime; even not prime
                if (modulus_reg <= W'(1))
                begin
                    res_next   = '{key_value: '0, modulus_not_prime: 1'b1};
                    state_next = ST_DONE;
                end
                else if (modulus_reg <= W'(3))
                    state_next = ST_REDBASE;
                else if (!modulus_reg[0])
                begin
                    res_next   = '{key_value: '0, modulus_not_prime: 1'b1};
                    state_next = ST_DONE;
                end
                else
                begin
                    d_next     = W'(3);
                    go_next    = 1'b0;
                    state_next = ST_DIVA;
                end
            end
            ST_DIVA, ST_DIVB:
            begin
                // remainder of modulus by d (ST_DIVA) or d+2 (ST_DIVB)
                su_b = (state_reg == ST_DIVB) ? d_plus[W-1:0] : d_reg;
                if (!go_reg)
                begin
                    su_start = 1'b1;
                    go_next  = 1'b1;
                end
                else if (!su_busy)
                begin
                    go_next = 1'b0;
                    if (su_result == '0)
                    begin
                        res_next   = '{key_value: '0, modulus_not_prime: 1'b1};
                        state_next = ST_DONE;
                    end
                    else if (state_reg == ST_DIVA && d_reg != W'(3))
                        state_next = ST_DIVB;
                    else
                    begin
                        if (d_reg == W'(3))
                            d_next = W'(5);
                        else
                            d_next = d_reg + W'(6);
                        state_next = ST_BOUND;
                    end
                end
            end
            ST_BOUND:
            begin
                // continue while d*d <= modulus
                su_op = SOP_SQDIV;
                su_a  = d_reg;
                su_b  = d_reg;
                if (!go_reg)
                begin
                    su_start = 1'b1;
                    go_next  = 1'b1;
                end
                else if (!su_busy)
                begin
                    go_next = 1'b0;
                    if (d_reg < W'(5) || su_result > {{W{1'b0}}, modulus_reg})
                        state_next = ST_REDBASE;
                    else
                        state_next = ST_DIVA;
                end
            end
            ST_REDBASE:
            begin
                // reduce the base mod modulus
                su_a = base_reg;
                su_b = modulus_reg;
                if (!go_reg)
                begin
                    su_start = 1'b1;
                    go_next  = 1'b1;
                end
                else if (!su_busy)
                begin
                    go_next    = 1'b0;
                    base_next  = su_result[W-1:0];
                    acc_next   = W'(1);
                    e_next     = secret_reg;
                    ecnt_next  = EBC'(W);
                    state_next = ST_EXP_MUL;
                end
            end
            ST_EXP_MUL:
            begin
                su_op = SOP_MUL;
                su_a  = acc_reg;
                su_b  = base_reg;
                if (!e_reg[0])
                    state_next = ST_EXP_SQR;
                else if (!go_reg)
                begin
                    su_start = 1'b1;
                    go_next  = 1'b1;
                end
                else if (!su_busy)
                begin
                    go_next    = 1'b0;
                    acc_next   = su_result[W-1:0];
                    state_next = ST_EXP_SQR;
                end
            end
            ST_EXP_SQR:
            begin
                su_op = SOP_MUL;
                su_a  = base_reg;
                su_b  = base_reg;
                if (!go_reg)
                begin
                    su_start = 1'b1;
                    go_next  = 1'b1;
                end
                else if (!su_busy)
                begin
                    go_next    = 1'b0;
                    base_next  = su_result[W-1:0];
                    state_next = ST_EXP_NEXT;
                end
            end
            ST_EXP_NEXT:
            begin
                // advance to next exponent bit
                e_next    = {1'b0, e_reg[W-1:1]};
                ecnt_next = ecnt_reg - 1'b1;
                if (ecnt_reg == EBC'(1))
                begin
                    res_next   = '{key_value: acc_reg, modulus_not_prime: 1'b0};
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_EXP_MUL;
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        d_reg    <= d_next;
        e_reg    <= e_next;
        ecnt_reg <= ecnt_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    // a passed result never carries a nonzero key with the flag set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.modulus_not_prime |-> out_data.key_value == '0)
        else $error("flagged result with nonzero key");

    // a passed key is below the modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.modulus_not_prime |-> out_data.key_value < modulus_reg)
        else $error("key not reduced");

    // the unit is launched only when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        su_start |-> !su_busy)
        else $error("serial unit restarted while busy");

    // a request is taken only while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_SMALL)
        else $error("request accepted outside idle");

endmodule

// ===== hdl/dhme_serial_unit.sv =====
// Bit-serial arithmetic unit: remainder, modular product and plain square.
// Processes one bit of the operand per cycle. Depends on dhme_pkg.
module dhme_serial_unit #(
    parameter int VALUE_BITS = dhme_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  dhme_pkg::sop_t        op,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    input  logic [VALUE_BITS-1:0] m,
    output logic                  busy,
    output logic [2*VALUE_BITS-1:0] result
);
    import dhme_pkg::*;

    localparam int W   = VALUE_BITS;
    localparam int CNT = $clog2(W + 1);

    sop_t             op_reg;
    logic [CNT-1:0]   cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [W-1:0]     sh_reg, sh_next;       // dividend or multiplier bits
    logic [2*W-1:0]   add_reg, add_next;     // doubled addend
    logic [2*W-1:0]   acc_reg, acc_next;     // remainder or accumulator
    logic [W-1:0]     m_reg;                 // divisor or modulus
    logic [2*W:0]     trial;
    logic [2*W+1:0]   sum;

    assign busy   = busy_reg;
    assign result = acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        add_next  = add_reg;
        acc_next  = acc_reg;
        trial     = '0;
        sum       = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT'(W);
            sh_next   = (op == SOP_REM) ? a : b;
            add_next  = {{W{1'b0}}, a};
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                SOP_REM:
                begin
                    // shift in next dividend bit, subtract if it fits
                    trial = {acc_reg, sh_reg[W-1]};
                    if (trial >= {{(W+1){1'b0}}, m_reg})
                        trial = trial - {{(W+1){1'b0}}, m_reg};
                    acc_next = trial[2*W-1:0];
                    sh_next  = {sh_reg[W-2:0], 1'b0};
                end
                SOP_MUL:
                begin
                    sum = {2'b00, acc_reg} + {2'b00, add_reg};
                    if (sh_reg[0])
                        acc_next = (sum >= {{(W+2){1'b0}}, m_reg})
                            ? sum[2*W-1:0] - {{W{1'b0}}, m_reg} : sum[2*W-1:0];
                    sum = {1'b0, add_reg, 1'b0};
                    add_next = (sum >= {{(W+2){1'b0}}, m_reg})
                        ? sum[2*W-1:0] - {{W{1'b0}}, m_reg} : sum[2*W-1:0];
                    sh_next = {1'b0, sh_reg[W-1:1]};
                end
                default:
                begin
                    sum = {2'b00, acc_reg} + {2'b00, add_reg};
                    if (sh_reg[0])
                        acc_next = sum[2*W-1:0];
                    add_next = {add_reg[2*W-2:0], 1'b0};
                    sh_next  = {1'b0, sh_reg[W-1:1]};
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= SOP_REM;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (start)
                op_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        add_reg <= add_next;
        acc_reg <= acc_next;
        if (start)
            m_reg <= (op == SOP_REM) ? b : m;
    end

endmodule
